// File: hdl/hpack_pkg.sv
// Package: shared types, constants and event codes of the HPACK header block parser.
`default_nettype none
package hpack_pkg;
    localparam int LENGTH_BITS = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW = 2;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_NAME_LEN   = 4'd1,
        PH_NAME_CONT  = 4'd2,
        PH_NAME_STR   = 4'd3,
        PH_VALUE_LEN  = 4'd4,
        PH_VALUE_CONT = 4'd5,
        PH_VALUE_STR  = 4'd6
    } t_phase;

    typedef enum logic [2:0] {
        EV_INDEXED    = 3'd0,
        EV_NAME_BYTE  = 3'd1,
        EV_VALUE_BYTE = 3'd2,
        EV_HEADER_END = 3'd3,
        EV_BLOCK_END  = 3'd4,
        EV_ERROR      = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        REG_TABLE_ENTRIES = 2'd0,
        REG_NAME_KEEP     = 2'd1,
        REG_VALUE_KEEP    = 2'd2
    } t_reg_index;

    // Byte classes found by the front end
    typedef enum logic [2:0] {
        CL_INDEXED   = 3'd0,
        CL_LIT_INDEX = 3'd1,
        CL_LIT_NAME  = 3'd2,
        CL_IGNORE    = 3'd3
    } t_class;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_last;
        t_class     cls;
        logic [6:0] idx;
    } t_word;

    typedef struct packed {
        t_event                 ev;
        logic [6:0]             table_index;
        logic [7:0]             out_byte;
        logic [LENGTH_BITS-1:0] name_length;
        logic [LENGTH_BITS-1:0] value_length;
        logic                   name_huffman;
        logic                   value_huffman;
        logic                   result_last;
    } t_result;
endpackage
`default_nettype wire

// File: hdl/hpack_front.sv
// Front end: accept bytes, classify first-byte patterns, feed a short queue.
`default_nettype none
module hpack_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    output logic                o_full,
    input  wire  [7:0]          i_data_byte,
    input  wire                 i_block_last,
    output hpack_pkg::t_word    o_word,
    output logic                o_valid,
    input  wire                 i_take
);
    hpack_pkg::t_word            r_mem [hpack_pkg::QUEUE_DEPTH];
    logic [hpack_pkg::QUEUE_AW-1:0] r_wp, r_rp;
    logic [hpack_pkg::QUEUE_AW:0]   r_cnt;
    hpack_pkg::t_word            w_in;
    logic                        w_wr, w_rd;

    always_comb begin
        w_in.data_byte  = i_data_byte;
        w_in.block_last = i_block_last;
        w_in.idx        = i_data_byte[6:0];
        if (i_data_byte[7]) begin
            w_in.cls = hpack_pkg::CL_INDEXED;
        end else if (i_data_byte[6]) begin
            w_in.cls = hpack_pkg::CL_LIT_INDEX;
            w_in.idx = {1'b0, i_data_byte[5:0]};
        end else if (i_data_byte == 8'h00 || i_data_byte == 8'h10) begin
            w_in.cls = hpack_pkg::CL_LIT_NAME;
        end else begin
            w_in.cls = hpack_pkg::CL_IGNORE;
        end
    end

    assign o_full  = (r_cnt == (hpack_pkg::QUEUE_AW+1)'(hpack_pkg::QUEUE_DEPTH));
    assign w_wr    = i_push && !o_full;
    assign o_valid = (r_cnt != '0);
    assign w_rd    = i_take && o_valid;
    assign o_word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_in;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (hpack_pkg::QUEUE_AW+1)'(w_wr) - (hpack_pkg::QUEUE_AW+1)'(w_rd);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (hpack_pkg::QUEUE_AW+1)'(hpack_pkg::QUEUE_DEPTH))
        else $error("front queue overfilled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr && !w_rd |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("front queue count lost a write");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !w_rd)
        else $error("front queue read while empty");
endmodule
`default_nettype wire

// File: hdl/hpack_back.sv
// Back end: parse state machine producing up to three results per byte.
`default_nettype none
module hpack_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  hpack_pkg::t_word    i_word,
    input  wire                 i_valid,
    output logic                o_take,
    input  wire  [6:0]          i_table_entries,
    input  wire  [7:0]          i_name_keep,
    input  wire  [7:0]          i_value_keep,
    output hpack_pkg::t_result  o_res0,
    output hpack_pkg::t_result  o_res1,
    output hpack_pkg::t_result  o_res2,
    output logic [1:0]          o_nres,
    input  wire                 i_room
);
    localparam int LB = hpack_pkg::LENGTH_BITS;

    hpack_pkg::t_phase r_phase, n_phase;
    logic [LB:0]       r_acc, n_acc;
    logic [5:0]        r_shift, n_shift;
    logic [LB-1:0]     r_rem, n_rem;
    logic [7:0]        r_kept, n_kept;
    logic              r_huf, n_huf;
    logic [6:0]        r_nidx, n_nidx;
    logic [LB-1:0]     r_nlen, n_nlen;
    logic              r_nhuf, n_nhuf;
    logic              r_err, n_err;

    hpack_pkg::t_result w_r [3];
    logic [1:0]        w_n;
    logic [7:0]        b;
    logic [6:0]        v;
    logic              w_val, w_known, w_fail;
    logic [LB:0]       w_sum;
    logic [7:0]        w_lim;

    assign o_take = i_valid && i_room;

    always_comb begin
        n_phase = r_phase; n_acc = r_acc; n_shift = r_shift; n_rem = r_rem;
        n_kept = r_kept; n_huf = r_huf; n_nidx = r_nidx; n_nlen = r_nlen;
        n_nhuf = r_nhuf; n_err = r_err;
        w_n = '0;
        for (int k = 0; k < 3; k++) w_r[k] = '0;
        b = i_word.data_byte;
        v = b[6:0];
        w_known = 1'b0;
        w_fail = 1'b0;
        w_sum = '0;
        w_val = (r_phase == hpack_pkg::PH_VALUE_LEN) || (r_phase == hpack_pkg::PH_VALUE_CONT)
             || (r_phase == hpack_pkg::PH_VALUE_STR);
        w_lim = w_val ? i_value_keep : i_name_keep;

        if (!r_err) begin
            case (r_phase)
                hpack_pkg::PH_IDLE: begin
                    case (i_word.cls)
                        hpack_pkg::CL_INDEXED: begin
                            if (i_word.idx == '0) begin
                                w_fail = 1'b1;
                            end else if (i_word.idx < i_table_entries) begin
                                w_r[0].ev = hpack_pkg::EV_INDEXED;
                                w_r[0].table_index = i_word.idx;
                                w_n = 2'd1;
                            end
                        end
                        hpack_pkg::CL_LIT_INDEX: begin
                            n_acc = '0; n_shift = '0; n_rem = '0; n_kept = '0;
                            n_huf = 1'b0; n_nlen = '0; n_nhuf = 1'b0; n_nidx = '0;
                            if (i_word.idx == '0) begin
                                n_phase = hpack_pkg::PH_NAME_LEN;
                            end else begin
                                n_nidx = (i_word.idx < i_table_entries) ? i_word.idx : '0;
                                n_phase = hpack_pkg::PH_VALUE_LEN;
                            end
                        end
                        hpack_pkg::CL_LIT_NAME: begin
                            n_acc = '0; n_shift = '0; n_rem = '0; n_kept = '0;
                            n_huf = 1'b0; n_nlen = '0; n_nhuf = 1'b0; n_nidx = '0;
                            n_phase = hpack_pkg::PH_NAME_LEN;
                        end
                        default: ;
                    endcase
                end
                hpack_pkg::PH_NAME_LEN, hpack_pkg::PH_VALUE_LEN: begin
                    n_huf = b[7];
                    n_acc = (LB+1)'(v);
                    n_shift = '0;
                    if (v != 7'h7F) w_known = 1'b1;
                    else n_phase = w_val ? hpack_pkg::PH_VALUE_CONT : hpack_pkg::PH_NAME_CONT;
                end
                hpack_pkg::PH_NAME_CONT, hpack_pkg::PH_VALUE_CONT: begin
                    if (v != '0) begin
                        if (r_shift >= 6'(LB)) begin
                            w_fail = 1'b1;
                        end else begin
                            w_sum = r_acc + ((LB+1)'(v) << r_shift);
                            // carry out of 7 bits past the top also overflows
                            if (w_sum[LB] || (r_shift + 6'd7 > 6'(LB)
                                && ((v >> (6'(LB) - r_shift)) != '0))) w_fail = 1'b1;
                            n_acc = w_sum;
                        end
                    end
                    if (!w_fail) begin
                        n_shift = (r_shift + 6'd7 > 6'(LB)) ? 6'(LB) : r_shift + 6'd7;
                        if (!b[7]) w_known = 1'b1;
                    end
                end
                hpack_pkg::PH_NAME_STR, hpack_pkg::PH_VALUE_STR: begin
                    if (!r_huf && r_kept < w_lim) begin
                        w_r[0].ev = w_val ? hpack_pkg::EV_VALUE_BYTE : hpack_pkg::EV_NAME_BYTE;
                        w_r[0].out_byte = b;
                        w_n = 2'd1;
                        n_kept = r_kept + 1'b1;
                    end
                    n_rem = (r_rem != '0) ? r_rem - 1'b1 : r_rem;
                    if (n_rem == '0) begin
                        if (!w_val) begin
                            n_nlen = r_acc[LB-1:0]; n_nhuf = r_huf;
                            n_phase = hpack_pkg::PH_VALUE_LEN;
                        end else begin
                            w_r[w_n].ev = hpack_pkg::EV_HEADER_END;
                            w_r[w_n].table_index = r_nidx;
                            w_r[w_n].name_length = r_nlen;
                            w_r[w_n].value_length = r_acc[LB-1:0];
                            w_r[w_n].name_huffman = r_nhuf;
                            w_r[w_n].value_huffman = r_huf;
                            w_n = w_n + 1'b1;
                            n_phase = hpack_pkg::PH_IDLE;
                            n_acc = '0; n_shift = '0; n_rem = '0; n_kept = '0; n_huf = 1'b0;
                            n_nidx = '0; n_nlen = '0; n_nhuf = 1'b0;
                        end
                    end
                end
                default: n_phase = hpack_pkg::PH_IDLE;
            endcase

            if (w_known) begin
                if (n_acc == '0) begin
                    if (!w_val) begin
                        n_nlen = '0; n_nhuf = n_huf;
                        n_phase = hpack_pkg::PH_VALUE_LEN;
                    end else begin
                        w_r[0].ev = hpack_pkg::EV_HEADER_END;
                        w_r[0].table_index = r_nidx;
                        w_r[0].name_length = r_nlen;
                        w_r[0].name_huffman = r_nhuf;
                        w_r[0].value_huffman = n_huf;
                        w_n = 2'd1;
                        n_phase = hpack_pkg::PH_IDLE;
                        n_acc = '0; n_shift = '0; n_rem = '0; n_kept = '0; n_huf = 1'b0;
                        n_nidx = '0; n_nlen = '0; n_nhuf = 1'b0;
                    end
                end else begin
                    n_rem = n_acc[LB-1:0];
                    n_kept = '0;
                    n_phase = w_val ? hpack_pkg::PH_VALUE_STR : hpack_pkg::PH_NAME_STR;
                end
            end

            if (w_fail) begin
                w_r[0] = '0;
                w_r[0].ev = hpack_pkg::EV_ERROR;
                w_n = 2'd1;
                n_phase = hpack_pkg::PH_IDLE;
                n_acc = '0; n_shift = '0; n_rem = '0; n_kept = '0; n_huf = 1'b0;
                n_nidx = '0; n_nlen = '0; n_nhuf = 1'b0;
                n_err = 1'b1;
            end
        end

        if (i_word.block_last) begin
            if (!n_err && n_phase != hpack_pkg::PH_IDLE) begin
                w_r[w_n] = '0;
                w_r[w_n].ev = hpack_pkg::EV_ERROR;
                w_n = w_n + 1'b1;
            end
            w_r[w_n] = '0;
            w_r[w_n].ev = hpack_pkg::EV_BLOCK_END;
            w_n = w_n + 1'b1;
            n_phase = hpack_pkg::PH_IDLE;
            n_acc = '0; n_shift = '0; n_rem = '0; n_kept = '0; n_huf = 1'b0;
            n_nidx = '0; n_nlen = '0; n_nhuf = 1'b0;
            n_err = 1'b0;
        end
        if (w_n != '0) w_r[w_n - 1'b1].result_last = 1'b1;
    end

    assign o_res0 = w_r[0];
    assign o_res1 = w_r[1];
    assign o_res2 = w_r[2];
    assign o_nres = o_take ? w_n : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hpack_pkg::PH_IDLE;
            r_acc <= '0; r_shift <= '0; r_rem <= '0; r_kept <= '0; r_huf <= 1'b0;
            r_nidx <= '0; r_nlen <= '0; r_nhuf <= 1'b0; r_err <= 1'b0;
        end else if (o_take) begin
            r_phase <= n_phase; r_acc <= n_acc; r_shift <= n_shift; r_rem <= n_rem;
            r_kept <= n_kept; r_huf <= n_huf; r_nidx <= n_nidx; r_nlen <= n_nlen;
            r_nhuf <= n_nhuf; r_err <= n_err;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && i_word.block_last |=> r_phase == hpack_pkg::PH_IDLE && !r_err)
        else $error("block end left parse state");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> r_phase == hpack_pkg::PH_IDLE)
        else $error("error state while parsing");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && i_word.block_last |-> o_nres != 2'd0)
        else $error("block end without result");
endmodule
`default_nettype wire

// File: hdl/hpack_out_queue.sv
// Result queue: takes up to three results a cycle, hands out one.
`default_nettype none
module hpack_out_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  hpack_pkg::t_result  i_res0,
    input  hpack_pkg::t_result  i_res1,
    input  hpack_pkg::t_result  i_res2,
    input  wire  [1:0]          i_nres,
    output logic                o_room,
    output hpack_pkg::t_result  o_head,
    output logic                o_empty,
    input  wire                 i_pop
);
    hpack_pkg::t_result r_mem [hpack_pkg::OUT_DEPTH];
    logic [hpack_pkg::OUT_AW-1:0] r_wp, r_rp;
    logic [hpack_pkg::OUT_AW:0]   r_cnt;
    logic w_rd;

    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign w_rd    = i_pop && !o_empty;
    // room for a worst-case byte of three results
    assign o_room  = (r_cnt <= (hpack_pkg::OUT_AW+1)'(hpack_pkg::OUT_DEPTH - 3));

    always_ff @(posedge i_clk) begin
        if (i_nres > 2'd0) r_mem[r_wp] <= i_res0;
        if (i_nres > 2'd1) r_mem[r_wp + 1'b1] <= i_res1;
        if (i_nres > 2'd2) r_mem[r_wp + 2'd2] <= i_res2;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + hpack_pkg::OUT_AW'(i_nres);
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (hpack_pkg::OUT_AW+1)'(i_nres) - (hpack_pkg::OUT_AW+1)'(w_rd);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (hpack_pkg::OUT_AW+1)'(hpack_pkg::OUT_DEPTH))
        else $error("result queue overfilled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_room |-> i_nres == 2'd0)
        else $error("results written without room");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !w_rd)
        else $error("result read while empty");
endmodule
`default_nettype wire

// File: hdl/hpack_header_block_parser.sv
// Top level of the HPACK header block parser: config registers, front, back, result queue.
// A byte accepted into the front queue is parsed by the combinational back end, which writes its
// results into the result queue; from there they can be popped.
// Throughput: one byte a cycle; the back end stalls unless three result slots are free.
// Reset (i_rst_n low, synchronous) empties both queues, clears parse state and
// restores the registers to 61, 127 and 255.
`default_nettype none
module hpack_header_block_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_block_last,
    output logic        empty,
    input  wire         pop,
    output logic [2:0]  o_event_res,
    output logic [6:0]  o_table_index,
    output logic [7:0]  o_out_byte,
    output logic [hpack_pkg::LENGTH_BITS-1:0] o_name_length,
    output logic [hpack_pkg::LENGTH_BITS-1:0] o_value_length,
    output logic        o_name_huffman,
    output logic        o_value_huffman,
    output logic        o_result_last,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);
    logic [6:0] r_table_entries;
    logic [7:0] r_name_keep;
    logic [7:0] r_value_keep;

    hpack_pkg::t_word   w_word;
    logic               w_valid, w_take, w_room;
    hpack_pkg::t_result w_r0, w_r1, w_r2, w_head;
    logic [1:0]         w_nres;

    // Register writes take effect at once: write only while no byte is in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_entries <= 7'd61;
            r_name_keep     <= 8'd127;
            r_value_keep    <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hpack_pkg::REG_TABLE_ENTRIES: r_table_entries <= i_cfg_data[6:0];
                hpack_pkg::REG_NAME_KEEP:     r_name_keep     <= i_cfg_data;
                hpack_pkg::REG_VALUE_KEEP:    r_value_keep    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: accept and classify each word
    hpack_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_data_byte(i_data_byte), .i_block_last(i_block_last),
        .o_word(w_word), .o_valid(w_valid), .i_take(w_take)
    );

    // Back: advance the parse and emit results
    hpack_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_word(w_word), .i_valid(w_valid),
        .o_take(w_take), .i_table_entries(r_table_entries),
        .i_name_keep(r_name_keep), .i_value_keep(r_value_keep),
        .o_res0(w_r0), .o_res1(w_r1), .o_res2(w_r2), .o_nres(w_nres), .i_room(w_room)
    );

    // Hold results until popped
    hpack_out_queue u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_res0(w_r0), .i_res1(w_r1), .i_res2(w_r2),
        .i_nres(w_nres), .o_room(w_room), .o_head(w_head), .o_empty(empty), .i_pop(pop)
    );

    assign o_event_res     = w_head.ev;
    assign o_table_index   = w_head.table_index;
    assign o_out_byte      = w_head.out_byte;
    assign o_name_length   = w_head.name_length;
    assign o_value_length  = w_head.value_length;
    assign o_name_huffman  = w_head.name_huffman;
    assign o_value_huffman = w_head.value_huffman;
    assign o_result_last   = w_head.result_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_table_entries == $past(r_table_entries) || $past(i_cfg_we))
        else $error("table size changed without a write");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_event_res <= 3'd5)
        else $error("undefined event code on output");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_event_res == 3'd4 |-> o_result_last)
        else $error("block end not last result");
endmodule
`default_nettype wire
